// File: hw/rtl/ece_pkg.sv
// shared types and constants for the evidence combine engine
package ece_pkg;

	localparam int OPCODE_W = 4;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 6;

	typedef enum logic [3:0] {
		OP_CLEAR    = 4'd0,
		OP_ADD      = 4'd1,
		OP_OMEGA    = 4'd2,
		OP_COMBINE  = 4'd3,
		OP_FINISH   = 4'd4,
		OP_BELIEF   = 4'd5,
		OP_PLAUS    = 4'd6,
		OP_MOST_BEL = 4'd7,
		OP_MOST_PL  = 4'd8,
		OP_BEST     = 4'd9,
		OP_CONFLICT = 4'd10
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_CONFLICT = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OMEGA_SUM,
		S_COMBINE,
		S_DIV,
		S_NORM,
		S_QUERY,
		S_RANK,
		S_RANK_NEXT,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;      // capture the request
		logic       clr_acc;   // zero the running sum
		logic       scan;      // process table entry at walk index
		logic       walk_rst;  // restart the table walk
		logic       div_start;
		logic       div_step;
		logic       rank_rst;  // restart hypothesis loop
		logic       rank_next; // close one hypothesis
		logic       finish;    // commit the request result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       walk_last; // walk index past last entry
		logic       div_done;
		logic       rank_last;
	} dp_sts_t;

endpackage

// File: hw/rtl/ece_ctrl.sv
// controller state machine sequencing table walks, division and rankings
module ece_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  ece_pkg::opcode_t    op,
	input  logic                out_busy,
	input  ece_pkg::dp_sts_t    sts,
	output logic                idle,
	output ece_pkg::dp_cmd_t    cmd
);
	ece_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ece_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		idle    = 1'b0;
		case (state_q)
			ece_pkg::S_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					cmd.load     = 1'b1;
					cmd.clr_acc  = 1'b1;
					cmd.walk_rst = 1'b1;
					cmd.rank_rst = 1'b1;
					case (op)
						ece_pkg::OP_OMEGA:   state_d = ece_pkg::S_OMEGA_SUM;
						ece_pkg::OP_COMBINE: state_d = ece_pkg::S_COMBINE;
						ece_pkg::OP_FINISH:  state_d = ece_pkg::S_DIV;
						ece_pkg::OP_BELIEF,
						ece_pkg::OP_PLAUS:   state_d = ece_pkg::S_QUERY;
						ece_pkg::OP_MOST_BEL,
						ece_pkg::OP_MOST_PL,
						ece_pkg::OP_BEST:    state_d = ece_pkg::S_RANK;
						default:             state_d = ece_pkg::S_DONE;
					endcase
				end
			end
			ece_pkg::S_OMEGA_SUM, ece_pkg::S_COMBINE, ece_pkg::S_QUERY: begin
				if (sts.walk_last) state_d = ece_pkg::S_DONE;
				else cmd.scan = 1'b1;
			end
			ece_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.walk_rst = 1'b1;
					state_d = ece_pkg::S_NORM;
				end
			end
			ece_pkg::S_NORM: begin
				if (sts.walk_last) state_d = ece_pkg::S_DONE;
				else cmd.scan = 1'b1;
			end
			ece_pkg::S_RANK: begin
				if (sts.walk_last) state_d = ece_pkg::S_RANK_NEXT;
				else cmd.scan = 1'b1;
			end
			ece_pkg::S_RANK_NEXT: begin
				cmd.rank_next = 1'b1;
				cmd.walk_rst  = 1'b1;
				if (sts.rank_last) state_d = ece_pkg::S_DONE;
				else state_d = ece_pkg::S_RANK;
			end
			ece_pkg::S_DONE: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = ece_pkg::S_IDLE;
				end
			end
			default: state_d = ece_pkg::S_IDLE;
		endcase
		// division starts on entry from idle
		cmd.div_start = in_fire && state_q == ece_pkg::S_IDLE && op == ece_pkg::OP_FINISH;
	end

endmodule

// File: hw/rtl/ece_datapath.sv
// table memories, walk counter, accumulators, divider and result registers
module ece_datapath #(
	parameter int HB = 32,
	parameter int ME = 64,
	parameter int FB = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ece_pkg::dp_cmd_t       cmd,
	output ece_pkg::dp_sts_t       sts,
	input  logic [ece_pkg::CFG_W-1:0] hyp_count,
	input  ece_pkg::opcode_t       op,
	input  logic [FB:0]            mass_in,
	input  logic [HB-1:0]          mask_in,
	output logic [1:0]             res_status,
	output logic [FB:0]            res_mass,
	output logic [$clog2(HB)-1:0]  res_best,
	output logic [$clog2(ME+1)-1:0] res_count
);
	localparam int CW = $clog2(ME + 1);
	localparam int AW = $clog2(ME);
	localparam int HW = $clog2(HB);
	localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

	logic [HB-1:0] fmask_mem [ME];
	logic [FB:0]   fmass_mem [ME];
	logic [HB-1:0] smask_mem [ME];
	logic [FB:0]   smass_mem [ME];

	logic [CW-1:0] fcount_q, scount_q, walk_q;
	logic [FB:0]   conflict_q, acc_q, mass_q;
	logic [HB-1:0] mask_q, full_mask;
	ece_pkg::opcode_t op_q;
	logic          sat_q, full_q;
	logic [HW-1:0] hyp_q;
	logic [FB:0]   bel_q, pl_q, top_bel_q, top_pl_q;
	logic [HW-1:0] best_q;
	logic          have_q;
	logic [HW:0]   live;

	// live hypotheses and full mask
	always_comb begin
		live = (HW + 1)'(hyp_count);
		if (hyp_count == '0) live = (HW + 1)'(1);
		if ({1'b0, hyp_count} > 7'(HB)) live = (HW + 1)'(HB);
		for (int b = 0; b < HB; b++) full_mask[b] = (b < int'(live));
	end

	// registered table read at the walk index
	logic [AW-1:0] rd_addr;
	logic [HB-1:0] fmask_rd, smask_rd;
	logic [FB:0]   fmass_rd, smass_rd;
	assign rd_addr = walk_q[AW-1:0];
	always_ff @(posedge clk) begin
		fmask_rd <= fmask_mem[rd_addr];
		fmass_rd <= fmass_mem[rd_addr];
		smask_rd <= smask_mem[rd_addr];
		smass_rd <= smass_mem[rd_addr];
	end

	// walk runs read then process, tracked by a phase bit
	logic phase_q;
	logic [CW-1:0] walk_lim;
	assign walk_lim = (op_q == ece_pkg::OP_FINISH) ? scount_q : fcount_q;
	assign sts.walk_last = (walk_q >= walk_lim) && !phase_q;

	// divider for 2^(2F)/den, restoring, one bit per cycle
	localparam int DW = 2 * FB + 1;
	logic [DW-1:0] quo_q;
	logic [FB+1:0] rem_q;
	logic [FB:0]   den_q;
	logic [$clog2(DW+1)-1:0] dcnt_q;
	logic [FB+1:0] rem_sh;
	assign rem_sh = {rem_q[FB:0], quo_q[DW-1]};
	assign sts.div_done = (dcnt_q == '0) && !cmd.div_start;

	logic [FB:0] prod_mass;
	logic [2*FB+1:0] prod;
	logic [DW+FB:0] nprod;
	logic [DW+FB:0] nrnd;
	assign prod = fmass_rd * mass_q;
	assign prod_mass = (FB + 1)'((prod + (2*FB+2)'(ONE >> 1)) >> FB);
	assign nprod = smass_rd * quo_q;
	assign nrnd  = (nprod + (DW+FB+1)'(ONE >> 1)) >> FB;

	logic [FB:0]   add_val;
	logic          hit, single;
	logic [HB-1:0] bitm;
	assign bitm = HB'(1) << hyp_q;
	assign single = (fmask_rd != '0) && ((fmask_rd & (fmask_rd - HB'(1))) == '0);
	assign sts.rank_last = (32'(hyp_q) + 1 >= 32'(live));

	function automatic logic [FB:0] satadd(input logic [FB:0] a, input logic [FB:0] b,
		output logic s);
		logic [FB+1:0] t;
		t = {1'b0, a} + {1'b0, b};
		s = (t > {1'b0, ONE});
		return s ? ONE : t[FB:0];
	endfunction

	logic [FB:0] sa_acc, sa_bel, sa_pl;
	logic        s_acc, s_bel, s_pl, win;
	logic [HB-1:0] x;
	always_comb begin
		x = fmask_rd & mask_q;
		add_val = (op_q == ece_pkg::OP_COMBINE) ? prod_mass : fmass_rd;
		sa_acc = satadd((op_q == ece_pkg::OP_COMBINE) ? conflict_q : acc_q, add_val, s_acc);
		sa_bel = satadd(bel_q, fmass_rd, s_bel);
		sa_pl  = satadd(pl_q, fmass_rd, s_pl);
		hit = 1'b0;
		case (op_q)
			ece_pkg::OP_BELIEF: hit = (fmask_rd & ~mask_q) == '0;
			ece_pkg::OP_PLAUS:  hit = x != '0;
			default:            hit = 1'b1;
		endcase
		case (op_q)
			ece_pkg::OP_MOST_BEL: win = bel_q > top_bel_q;
			ece_pkg::OP_MOST_PL:  win = pl_q > top_pl_q;
			default: win = bel_q > top_bel_q || (bel_q == top_bel_q && pl_q > top_pl_q);
		endcase
		win = win || !have_q;
	end

	logic [FB:0] nval;
	logic        nsat;
	always_comb begin
		nsat = 1'b0;
		nval = '0;
		if (smass_rd > den_q) begin
			nval = ONE;
			nsat = 1'b1;
		end else if (nrnd > (DW+FB+1)'(ONE)) begin
			nval = ONE;
			nsat = 1'b1;
		end else nval = nrnd[FB:0];
	end

	logic [CW-1:0] add_idx;
	assign add_idx = fcount_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mass_q <= (mass_in > ONE) ? ONE : mass_in;
			mask_q <= mask_in & full_mask;
		end
		if (cmd.finish && op_q == ece_pkg::OP_ADD && fcount_q < CW'(ME)) begin
			fmask_mem[add_idx[AW-1:0]] <= mask_q;
			fmass_mem[add_idx[AW-1:0]] <= mass_q;
		end
		if (cmd.finish && op_q == ece_pkg::OP_OMEGA && acc_q < ONE && fcount_q < CW'(ME)) begin
			fmask_mem[add_idx[AW-1:0]] <= full_mask;
			fmass_mem[add_idx[AW-1:0]] <= ONE - acc_q;
		end
		if (cmd.scan && phase_q && op_q == ece_pkg::OP_COMBINE && x != '0
			&& scount_q < CW'(ME)) begin
			smask_mem[scount_q[AW-1:0]] <= x;
			smass_mem[scount_q[AW-1:0]] <= prod_mass;
		end
		// total conflict keeps the table
		if (cmd.scan && phase_q && op_q == ece_pkg::OP_FINISH && conflict_q < ONE) begin
			fmask_mem[rd_addr - AW'(1)] <= smask_rd;
			fmass_mem[rd_addr - AW'(1)] <= nval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= '0; scount_q <= '0; conflict_q <= '0; walk_q <= '0;
			phase_q <= 1'b0; acc_q <= '0; sat_q <= 1'b0; full_q <= 1'b0;
			op_q <= ece_pkg::OP_CLEAR; hyp_q <= '0; bel_q <= '0; pl_q <= '0;
			top_bel_q <= '0; top_pl_q <= '0; best_q <= '0; have_q <= 1'b0;
			quo_q <= '0; rem_q <= '0; den_q <= '0; dcnt_q <= '0;
			res_status <= '0; res_mass <= '0; res_best <= '0;
		end else begin
			if (cmd.load) begin
				op_q   <= op;
				sat_q  <= (mass_in > ONE) && (op == ece_pkg::OP_ADD || op == ece_pkg::OP_COMBINE);
				full_q <= 1'b0;
				hyp_q  <= '0;
				have_q <= 1'b0;
				top_bel_q <= '0;
				top_pl_q  <= '0;
				best_q <= '0;
			end
			if (cmd.clr_acc) acc_q <= '0;
			if (cmd.walk_rst) begin
				walk_q <= '0;
				phase_q <= 1'b0;
				bel_q <= '0;
				pl_q <= '0;
			end
			if (cmd.scan) begin
				// phase 0 issues read, phase 1 consumes it
				phase_q <= !phase_q;
				if (!phase_q) walk_q <= walk_q + CW'(1);
				else begin
					case (op_q)
						ece_pkg::OP_OMEGA: acc_q <= sa_acc;
						ece_pkg::OP_BELIEF, ece_pkg::OP_PLAUS: if (hit) begin
							acc_q <= sa_acc;
							if (s_acc) sat_q <= 1'b1;
						end
						ece_pkg::OP_COMBINE: begin
							if (x != '0) begin
								if (scount_q < CW'(ME)) scount_q <= scount_q + CW'(1);
								else full_q <= 1'b1;
							end else begin
								conflict_q <= sa_acc;
								if (s_acc) sat_q <= 1'b1;
							end
						end
						ece_pkg::OP_FINISH: if (nsat) sat_q <= 1'b1;
						default: if ((fmask_rd & bitm) != '0) begin
							pl_q <= sa_pl;
							if (s_pl) sat_q <= 1'b1;
							if (single) begin
								bel_q <= sa_bel;
								if (s_bel) sat_q <= 1'b1;
							end
						end
					endcase
				end
			end
			if (cmd.rank_next) begin
				if (win) begin
					have_q <= 1'b1;
					top_bel_q <= bel_q;
					top_pl_q <= pl_q;
					best_q <= hyp_q;
				end
				hyp_q <= hyp_q + HW'(1);
			end
			if (cmd.div_start) begin
				den_q  <= ONE - conflict_q;
				quo_q  <= DW'(1) << (2 * FB);
				rem_q  <= '0;
				dcnt_q <= ($clog2(DW+1))'(DW);
			end else if (cmd.div_step && dcnt_q != '0) begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 1'b1;
			end
			if (cmd.finish) begin
				res_status <= ece_pkg::ST_OK;
				res_mass   <= '0;
				res_best   <= '0;
				case (op_q)
					ece_pkg::OP_CLEAR: begin
						fcount_q <= '0; scount_q <= '0; conflict_q <= '0;
					end
					ece_pkg::OP_ADD: begin
						if (fcount_q < CW'(ME)) fcount_q <= fcount_q + CW'(1);
						else res_status <= ece_pkg::ST_FULL;
						if (fcount_q < CW'(ME) && sat_q) res_status <= ece_pkg::ST_SAT;
					end
					ece_pkg::OP_OMEGA: if (acc_q < ONE) begin
						if (fcount_q < CW'(ME)) fcount_q <= fcount_q + CW'(1);
						else res_status <= ece_pkg::ST_FULL;
					end
					ece_pkg::OP_COMBINE: begin
						if (full_q) res_status <= ece_pkg::ST_FULL;
						else if (sat_q) res_status <= ece_pkg::ST_SAT;
					end
					ece_pkg::OP_FINISH: begin
						res_mass <= conflict_q;
						if (conflict_q >= ONE) res_status <= ece_pkg::ST_CONFLICT;
						else begin
							fcount_q <= scount_q;
							if (sat_q) res_status <= ece_pkg::ST_SAT;
						end
						scount_q <= '0; conflict_q <= '0;
					end
					ece_pkg::OP_BELIEF, ece_pkg::OP_PLAUS: begin
						res_mass <= acc_q;
						if (sat_q) res_status <= ece_pkg::ST_SAT;
					end
					ece_pkg::OP_MOST_BEL, ece_pkg::OP_MOST_PL, ece_pkg::OP_BEST: begin
						res_mass <= (op_q == ece_pkg::OP_MOST_PL) ? top_pl_q : top_bel_q;
						res_best <= best_q;
						if (sat_q) res_status <= ece_pkg::ST_SAT;
					end
					ece_pkg::OP_CONFLICT: begin
						res_mass <= conflict_q;
						scount_q <= '0; conflict_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// count after this step, the count only moves at commit
	assign res_count = fcount_q;

endmodule

// File: hw/rtl/evidence_combine_engine_top.sv
// top level: stream ports, configuration register, controller and datapath
// one request at a time; a table walk reads and then processes each of its N entries, so
// combine, belief, plausibility and omega walk the table once, clear and add walk nothing,
// finish runs the divider (33 divider steps) and then walks its S scratch entries, and
// rankings walk the table once per live hypothesis; all counts and the conflict sum clear
// on reset; the tables hold no reset value and are only read below their counts
module evidence_combine_engine_top #(
	parameter int HYPOTHESIS_BITS = 32,
	parameter int MAX_ENTRIES = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode, mass_value, hypothesis_mask
	input  logic [((FRACTION_BITS + HYPOTHESIS_BITS + 12) / 8) * 8 - 1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, result_mass, best_index, entry_count
	output logic [((FRACTION_BITS + $clog2(HYPOTHESIS_BITS) + $clog2(MAX_ENTRIES + 1) + 10)
		/ 8) * 8 - 1:0] m_tdata
);
	localparam int OUT_W = ((FRACTION_BITS + $clog2(HYPOTHESIS_BITS)
		+ $clog2(MAX_ENTRIES + 1) + 10) / 8) * 8;

	logic [5:0] hyp_count_q;
	logic idle, out_busy, in_fire, fin_q;
	ece_pkg::dp_cmd_t cmd;
	ece_pkg::dp_sts_t sts;
	logic [1:0] r_status;
	logic [FRACTION_BITS:0] r_mass;
	logic [$clog2(HYPOTHESIS_BITS)-1:0] r_best;
	logic [$clog2(MAX_ENTRIES+1)-1:0] r_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hyp_count_q <= 6'd32;
		else if (cfg_we) hyp_count_q <= cfg_wdata;
	end

	assign s_tready = idle;
	assign in_fire  = s_tvalid && s_tready;
	assign out_busy = m_tvalid && !m_tready;

	ece_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.op(ece_pkg::opcode_t'(s_tdata[3:0])), .out_busy(out_busy),
		.sts(sts), .idle(idle), .cmd(cmd)
	);

	ece_datapath #(.HB(HYPOTHESIS_BITS), .ME(MAX_ENTRIES), .FB(FRACTION_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .hyp_count(hyp_count_q),
		.op(ece_pkg::opcode_t'(s_tdata[3:0])), .mass_in(s_tdata[4 +: FRACTION_BITS+1]),
		.mask_in(s_tdata[FRACTION_BITS + 5 +: HYPOTHESIS_BITS]),
		.res_status(r_status), .res_mass(r_mass), .res_best(r_best), .res_count(r_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_q <= 1'b0;
		else if (cmd.finish) fin_q <= 1'b1;
		else if (m_tready) fin_q <= 1'b0;
	end
	assign m_tvalid = fin_q;
	assign m_tdata  = OUT_W'({r_count, r_best, r_mass, r_status});

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready) else $error("accepted while busy");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> s_tready) else $error("no idle after result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_busy |=> m_tvalid) else $error("result dropped");

endmodule

// File: bench/tb.sv
// self-checking testbench for the evidence combine engine, stream ports and config register
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned MASS_ONE = 64'd65536;
	localparam int TABLE_DEPTH = 64;
	localparam longint CYCLE_LIMIT = 5000000;

	// packed to match the result bus, lowest field last
	typedef struct packed {
		logic [6:0]  count;
		logic [4:0]  best;
		logic [16:0] mass;
		logic [1:0]  status;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	evidence_combine_engine_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// shadow of the engine state
	longint unsigned tbl_mask[TABLE_DEPTH], tbl_mass[TABLE_DEPTH];
	longint unsigned scr_mask[TABLE_DEPTH], scr_mass[TABLE_DEPTH];
	int              tbl_n, scr_n;
	longint unsigned conflict_acc;
	logic [5:0]      hyp_setting;

	answer_t pending_answers[$];
	int      requests_sent, answers_seen, error_count;
	int      recv_stall_pct, send_idle_pct, recv_hold;
	longint  cycle_count;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver side: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (recv_hold > 0) begin
			recv_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic int live_hyps();
		int h;
		h = hyp_setting;
		if (h == 0) h = 1;
		if (h > 32) h = 32;
		return h;
	endfunction

	function automatic longint unsigned full_mask();
		return (64'd1 << live_hyps()) - 64'd1;
	endfunction

	function automatic longint unsigned sum_capped(longint unsigned a, longint unsigned b,
			inout bit capped);
		longint unsigned s;
		s = a + b;
		if (s > MASS_ONE) begin
			capped = 1'b1;
			s = MASS_ONE;
		end
		return s;
	endfunction

	function automatic bit one_hot(longint unsigned m);
		return m != 0 && (m & (m - 1)) == 0;
	endfunction

	// computes the answer for one request and advances the shadow state
	function automatic answer_t evaluate_request(logic [3:0] op, logic [16:0] mass_in,
			logic [31:0] mask_in);
		longint unsigned mass, mask, res, best, used, den, factor, p, x, v;
		longint unsigned bel, pl, top_bel, top_pl, e;
		bit capped, full, have, win, dummy;
		logic [1:0] st;
		answer_t a;
		int i, j;
		mass = mass_in;
		mask = longint'(mask_in) & full_mask();
		res = 0; best = 0; capped = 0; full = 0; dummy = 0; st = ece_pkg::ST_OK;
		if (mass > MASS_ONE) begin
			mass = MASS_ONE;
			if (op == ece_pkg::OP_ADD || op == ece_pkg::OP_COMBINE) capped = 1;
		end
		case (op)
			ece_pkg::OP_CLEAR: begin
				tbl_n = 0; scr_n = 0; conflict_acc = 0;
			end
			ece_pkg::OP_ADD: begin
				if (tbl_n >= TABLE_DEPTH) full = 1;
				else begin
					tbl_mask[tbl_n] = mask; tbl_mass[tbl_n] = mass; tbl_n++;
				end
			end
			ece_pkg::OP_OMEGA: begin
				used = 0;
				for (i = 0; i < tbl_n; i++) used = sum_capped(used, tbl_mass[i], dummy);
				if (used < MASS_ONE) begin
					if (tbl_n >= TABLE_DEPTH) full = 1;
					else begin
						tbl_mask[tbl_n] = full_mask(); tbl_mass[tbl_n] = MASS_ONE - used;
						tbl_n++;
					end
				end
			end
			ece_pkg::OP_COMBINE: begin
				for (i = 0; i < tbl_n; i++) begin
					p = (tbl_mass[i] * mass + (MASS_ONE >> 1)) >> 16;
					x = tbl_mask[i] & mask;
					if (x != 0) begin
						if (scr_n >= TABLE_DEPTH) full = 1;
						else begin
							scr_mask[scr_n] = x; scr_mass[scr_n] = p; scr_n++;
						end
					end else begin
						conflict_acc = sum_capped(conflict_acc, p, capped);
					end
				end
			end
			ece_pkg::OP_FINISH: begin
				res = conflict_acc;
				if (conflict_acc >= MASS_ONE) begin
					st = ece_pkg::ST_CONFLICT;
				end else begin
					den = MASS_ONE - conflict_acc;
					factor = (64'd1 << 32) / den;
					for (i = 0; i < scr_n; i++) begin
						if (scr_mass[i] > den) begin
							v = MASS_ONE; capped = 1;
						end else begin
							v = (scr_mass[i] * factor + (MASS_ONE >> 1)) >> 16;
							if (v > MASS_ONE) begin
								v = MASS_ONE; capped = 1;
							end
						end
						tbl_mask[i] = scr_mask[i]; tbl_mass[i] = v;
					end
					tbl_n = scr_n;
				end
				scr_n = 0; conflict_acc = 0;
			end
			ece_pkg::OP_BELIEF: begin
				for (i = 0; i < tbl_n; i++)
					if ((tbl_mask[i] & ~mask) == 0) res = sum_capped(res, tbl_mass[i], capped);
			end
			ece_pkg::OP_PLAUS: begin
				for (i = 0; i < tbl_n; i++)
					if ((tbl_mask[i] & mask) != 0) res = sum_capped(res, tbl_mass[i], capped);
			end
			ece_pkg::OP_MOST_BEL, ece_pkg::OP_MOST_PL, ece_pkg::OP_BEST: begin
				have = 0; top_bel = 0; top_pl = 0;
				for (j = 0; j < live_hyps(); j++) begin
					bel = 0; pl = 0;
					for (i = 0; i < tbl_n; i++) begin
						e = tbl_mask[i];
						if (e[j]) begin
							pl = sum_capped(pl, tbl_mass[i], capped);
							if (one_hot(e)) bel = sum_capped(bel, tbl_mass[i], capped);
						end
					end
					if (!have) win = 1;
					else if (op == ece_pkg::OP_MOST_BEL) win = bel > top_bel;
					else if (op == ece_pkg::OP_MOST_PL) win = pl > top_pl;
					else win = bel > top_bel || (bel == top_bel && pl > top_pl);
					if (win) begin
						have = 1; top_bel = bel; top_pl = pl; best = j;
					end
				end
				res = (op == ece_pkg::OP_MOST_PL) ? top_pl : top_bel;
			end
			ece_pkg::OP_CONFLICT: begin
				res = conflict_acc;
				scr_n = 0; conflict_acc = 0;
			end
			default: ;
		endcase
		if (st == ece_pkg::ST_OK) begin
			if (full) st = ece_pkg::ST_FULL;
			else if (capped) st = ece_pkg::ST_SAT;
		end
		a.status = st;
		a.mass = res[16:0];
		a.best = best[4:0];
		a.count = tbl_n[6:0];
		return a;
	endfunction

	// one request, held until accepted; valid stays up until the next decision
	task automatic send_request(logic [3:0] op, logic [16:0] mass, logic [31:0] mask);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, mask, mass, op};
		do @(posedge clk); while (!s_tready);
		pending_answers = {pending_answers, evaluate_request(op, mass, mask)};
		requests_sent++;
		@(negedge clk);
	endtask

	// answer checker
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[30:0];
			answers_seen++;
			if (pending_answers.size() == 0) begin
				$error("answer with no request outstanding: %h", m_tdata);
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				if (got.status != want.status) begin
					$error("status expected %0d got %0d", want.status, got.status);
					error_count++;
				end
				if (got.mass != want.mass) begin
					$error("result_mass expected %0d got %0d", want.mass, got.mass);
					error_count++;
				end
				if (got.best != want.best) begin
					$error("best_index expected %0d got %0d", want.best, got.best);
					error_count++;
				end
				if (got.count != want.count) begin
					$error("entry_count expected %0d got %0d", want.count, got.count);
					error_count++;
				end
			end
		end
	end

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_hyp_count(logic [5:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		hyp_setting = v;
	endtask

	function automatic logic [31:0] pick_mask();
		case ($urandom_range(5))
			0: return 32'd1 << $urandom_range(31);
			1: return 32'd1 << $urandom_range(3);
			2: return $urandom_range(15);
			3: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_basic_ops();
		int k;
		send_request(ece_pkg::OP_CLEAR, '0, '0);
		send_request(ece_pkg::OP_ADD, 17'd70000, 32'h1);          // mass above one
		send_request(ece_pkg::OP_CLEAR, '0, '0);
		send_request(ece_pkg::OP_ADD, 17'h08000, 32'h0);          // empty mask kept
		send_request(ece_pkg::OP_ADD, 17'h04000, 32'h3);
		send_request(ece_pkg::OP_ADD, 17'h01000, 32'h4);
		send_request(ece_pkg::OP_OMEGA, '0, '0);
		send_request(ece_pkg::OP_BELIEF, '0, 32'h3);
		send_request(ece_pkg::OP_PLAUS, '0, 32'h1);
		send_request(ece_pkg::OP_MOST_BEL, '0, '0);
		send_request(ece_pkg::OP_MOST_PL, '0, '0);
		send_request(ece_pkg::OP_BEST, '0, '0);
		send_request(ece_pkg::OP_COMBINE, 17'h10000, 32'h1);
		send_request(ece_pkg::OP_COMBINE, 17'h08000, 32'h2);
		send_request(ece_pkg::OP_FINISH, '0, '0);
		send_request(ece_pkg::OP_CONFLICT, '0, '0);
		send_request(ece_pkg::OP_CLEAR, '0, '0);
		send_request(ece_pkg::OP_ADD, 17'h10000, 32'h1);
		send_request(ece_pkg::OP_OMEGA, '0, '0);                    // no mass left
		send_request(ece_pkg::OP_COMBINE, 17'h10000, 32'h2);      // everything conflicts
		send_request(ece_pkg::OP_FINISH, '0, '0);
		for (k = 1; k <= 5; k++)
			send_request(4'(ece_pkg::OP_CONFLICT + k), 17'h1FFFF, 32'hFFFFFFFF);
		send_request(ece_pkg::OP_PLAUS, 17'h1FFFF, 32'hFFFFFFFF);
	endtask

	task automatic test_capacity();
		int k;
		send_request(ece_pkg::OP_CLEAR, '0, '0);
		for (k = 0; k < TABLE_DEPTH; k++)
			send_request(ece_pkg::OP_ADD, 17'd1000, 32'hFFFFFFFF);
		send_request(ece_pkg::OP_ADD, 17'd1000, 32'h1);           // table full
		send_request(ece_pkg::OP_OMEGA, '0, '0);                    // table full
		send_request(ece_pkg::OP_COMBINE, 17'd1000, 32'hFFFFFFFF);
		send_request(ece_pkg::OP_COMBINE, 17'd1000, 32'h1);       // scratch full
		send_request(ece_pkg::OP_FINISH, '0, '0);
		send_request(ece_pkg::OP_BELIEF, '0, 32'hFFFFFFFF);
		send_request(ece_pkg::OP_CLEAR, '0, '0);
	endtask

	// mostly clear/build/combine/query sequences, some raw noise
	task automatic test_random(int n, int send_pct, int recv_pct);
		int stop_at, k, cnt, budget;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		stop_at = requests_sent + n;
		while (requests_sent < stop_at) begin
			if ($urandom_range(99) < 75) begin
				send_request(ece_pkg::OP_CLEAR, '0, '0);
				cnt = $urandom_range(1, 4);
				budget = 65536;
				for (k = 0; k < cnt; k++)
					send_request(ece_pkg::OP_ADD, 17'($urandom_range(0, budget / cnt)),
						pick_mask());
				if ($urandom_range(1))
					send_request(ece_pkg::OP_OMEGA, 17'($urandom), $urandom);
				send_request(4'($urandom_range(ece_pkg::OP_BELIEF, ece_pkg::OP_BEST)), '0,
					pick_mask());
				cnt = $urandom_range(1, 4);
				for (k = 0; k < cnt; k++)
					send_request(ece_pkg::OP_COMBINE, 17'($urandom_range(0, 65536)),
						pick_mask());
				if ($urandom_range(9) == 0) send_request(ece_pkg::OP_CONFLICT, '0, '0);
				else send_request(ece_pkg::OP_FINISH, '0, '0);
				send_request(4'($urandom_range(ece_pkg::OP_BELIEF, ece_pkg::OP_BEST)), '0,
					pick_mask());
				send_request(4'($urandom_range(ece_pkg::OP_BELIEF, ece_pkg::OP_BEST)), '0,
					pick_mask());
			end else begin
				send_request(4'($urandom_range(15)), 17'($urandom_range(17'h1FFFF)), $urandom);
			end
		end
	endtask

	// long output hold-off while requests keep coming
	task automatic test_backpressure();
		int k;
		send_idle_pct = 0;
		recv_hold = 3000;
		send_request(ece_pkg::OP_CLEAR, '0, '0);
		for (k = 0; k < 6; k++) send_request(ece_pkg::OP_ADD, 17'd8000, pick_mask());
		for (k = 0; k < 6; k++)
			send_request(4'($urandom_range(ece_pkg::OP_BELIEF, ece_pkg::OP_BEST)), '0,
				$urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		recv_hold = 0;
		recv_stall_pct = 0;
		send_idle_pct = 0;
		cycle_count = 0;
		requests_sent = 0;
		answers_seen = 0;
		error_count = 0;
		tbl_n = 0; scr_n = 0; conflict_acc = 0;
		hyp_setting = 6'd32;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_ops();
		test_capacity();
		write_hyp_count(6'd4);
		test_basic_ops();
		write_hyp_count(6'd0);                            // acts as one hypothesis
		test_random(60, 0, 0);
		write_hyp_count(6'd63);                           // acts as all 32
		test_random(200, 0, 0);
		write_hyp_count(6'd1);
		test_random(80, 59, 0);
		write_hyp_count(6'd3);
		test_random(200, 0, 59);
		write_hyp_count(6'($urandom_range(2, 31)));
		test_random(200, 19, 19);
		write_hyp_count(6'd32);
		test_backpressure();
		test_random(200, 19, 19);

		send_idle_pct = 0;
		wait_drained();
		repeat (50) @(posedge clk);
		$display("sent %0d requests, checked %0d answers, %0d mismatches",
			requests_sent, answers_seen, error_count);
		$display("covered all opcodes, full table and scratch, total conflict, several widths");
		if (error_count == 0 && pending_answers.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/ece_pkg.sv
hw/rtl/ece_ctrl.sv
hw/rtl/ece_datapath.sv
hw/rtl/evidence_combine_engine_top.sv
bench/tb.sv
